// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define CHK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that holds through reset as well
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bo2chs_pkg.sv =====
package bo2chs_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_SECTOR_SIZE_CODE   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SECTORS_PER_TRACK  = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD_COUNT         = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STEPS_PER_CYLINDER = 4'd3;

  localparam int LEN_W          = 24;
  localparam int BASE_SHIFT     = 7;   // 128 byte sectors at code zero
  localparam int CODE_W         = 2;
  localparam int CODE_SHIFT_MAX = 3;
  localparam int SPT_W          = 6;
  localparam int CYL_W          = 8;
  localparam int SEEK_W         = 9;
  localparam int DIV_STEP       = 4;   // quotient bits per divider stage

  localparam logic [CODE_W-1:0] RST_SIZE_CODE = 2'd2;
  localparam logic [SPT_W-1:0]  RST_SPT       = 6'd18;
  localparam logic              RST_HEADS2    = 1'b1;
  localparam logic              RST_STEPS2    = 1'b0;

  // geometry as the datapath sees it, already clamped to legal values
  typedef struct packed {
    logic [CODE_W-1:0] size_code;
    logic [SPT_W-1:0]  spt;
    logic              heads2;
    logic              steps2;
  } geom_t;

endpackage

// ===== rtl/bo2chs_in_if.sv =====
interface bo2chs_in_if #(
  parameter int OFFSET_BITS = 24
) ();
  logic                           valid;
  logic                           ready;
  logic [OFFSET_BITS-1:0]         byte_offset;
  logic [bo2chs_pkg::LEN_W-1:0]   transfer_length;

  modport source (output valid, byte_offset, transfer_length, input ready);
  modport sink (input valid, byte_offset, transfer_length, output ready);
endinterface

// ===== rtl/bo2chs_out_if.sv =====
interface bo2chs_out_if ();
  logic                            valid;
  logic                            ready;
  logic [bo2chs_pkg::CYL_W-1:0]    cylinder;
  logic                            head;
  logic [bo2chs_pkg::SPT_W-1:0]    sector;
  logic [bo2chs_pkg::SEEK_W-1:0]   seek_track;
  logic [bo2chs_pkg::LEN_W-1:0]    trimmed_length;
  logic                            was_trimmed;
  logic                            out_of_range;

  modport source (output valid, cylinder, head, sector, seek_track, trimmed_length,
                  was_trimmed, out_of_range, input ready);
  modport sink (input valid, cylinder, head, sector, seek_track, trimmed_length,
                was_trimmed, out_of_range, output ready);
endinterface

// ===== rtl/bo2chs_cfg_if.sv =====
interface bo2chs_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [bo2chs_pkg::CFG_ADDR_W-1:0]   addr;
  logic [bo2chs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/bo2chs_cfg_regs.sv =====
module bo2chs_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  bo2chs_cfg_if.sink          cfg_ch,
  output bo2chs_pkg::geom_t   geom
);

  logic [bo2chs_pkg::CODE_W-1:0] size_code_r;
  logic [bo2chs_pkg::SPT_W-1:0]  spt_r;
  logic                          heads2_r;
  logic                          steps2_r;
  logic                          wr;
  logic [bo2chs_pkg::SPT_W-1:0]  spt_wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  // zero sectors per track counts as one
  assign spt_wr = (cfg_ch.data[bo2chs_pkg::SPT_W-1:0] == '0) ?
                  bo2chs_pkg::SPT_W'(1) : cfg_ch.data[bo2chs_pkg::SPT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_code_r <= bo2chs_pkg::RST_SIZE_CODE;
      spt_r       <= bo2chs_pkg::RST_SPT;
      heads2_r    <= bo2chs_pkg::RST_HEADS2;
      steps2_r    <= bo2chs_pkg::RST_STEPS2;
    end else if (wr) begin
      case (cfg_ch.addr)
        bo2chs_pkg::REG_SECTOR_SIZE_CODE: begin
          size_code_r <= cfg_ch.data[bo2chs_pkg::CODE_W-1:0];
        end
        bo2chs_pkg::REG_SECTORS_PER_TRACK: begin
          spt_r <= spt_wr;
        end
        // codes two and three both mean two, zero and one mean one
        bo2chs_pkg::REG_HEAD_COUNT: begin
          heads2_r <= cfg_ch.data[1];
        end
        bo2chs_pkg::REG_STEPS_PER_CYLINDER: begin
          steps2_r <= cfg_ch.data[1];
        end
        default: begin
        end
      endcase
    end
  end

  assign geom.size_code = size_code_r;
  assign geom.spt       = spt_r;
  assign geom.heads2    = heads2_r;
  assign geom.steps2    = steps2_r;

endmodule

// ===== rtl/bo2chs_div_pipe.sv =====
module bo2chs_div_pipe #(
  parameter int DW     = 17,
  parameter int SIDE_W = 65
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bo2chs_pkg::SPT_W-1:0]  divisor,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [DW-1:0]                 in_num,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DW-1:0]                 out_quo,
  output logic [bo2chs_pkg::SPT_W-1:0]  out_rem,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int STEP = bo2chs_pkg::DIV_STEP;
  localparam int NSTG = (DW + STEP - 1) / STEP;
  localparam int PW   = NSTG * STEP;
  localparam int RW   = bo2chs_pkg::SPT_W;

  logic              v_r    [NSTG];
  logic [RW-1:0]     rem_r  [NSTG];
  logic [PW-1:0]     num_r  [NSTG];
  logic [PW-1:0]     quo_r  [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];
  logic              en     [NSTG+1];

  assign en[NSTG] = out_ready;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic              v_in;
    logic [RW-1:0]     rem_in;
    logic [PW-1:0]     num_in;
    logic [PW-1:0]     quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW-1:0]     rem_nxt;
    logic [PW-1:0]     num_nxt;
    logic [PW-1:0]     quo_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign num_in  = PW'(in_num);
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign num_in  = num_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign en[s] = !v_r[s] || en[s+1];

    // restoring division, four quotient bits per stage
    always_comb begin : blk_div
      logic [RW:0] trial;
      rem_nxt = rem_in;
      num_nxt = num_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int b = 0; b < STEP; b++) begin
        trial   = {rem_nxt, num_nxt[PW-1]};
        num_nxt = {num_nxt[PW-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = RW'(trial - {1'b0, divisor});
          quo_nxt = {quo_nxt[PW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[RW-1:0];
          quo_nxt = {quo_nxt[PW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s]  <= rem_nxt;
        num_r[s]  <= num_nxt;
        quo_r[s]  <= quo_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];
  assign out_quo   = quo_r[NSTG-1][DW-1:0];
  assign out_rem   = rem_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule

// ===== rtl/bo2chs_post.sv =====
module bo2chs_post #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  bo2chs_pkg::geom_t                          geom,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [OFFSET_BITS-bo2chs_pkg::BASE_SHIFT-1:0] quo,
  input  logic [bo2chs_pkg::SPT_W-1:0]               rem,
  input  logic [OFFSET_BITS-bo2chs_pkg::BASE_SHIFT-1:0] lsec,
  input  logic [OFFSET_BITS-1:0]                     off,
  input  logic [bo2chs_pkg::LEN_W-1:0]               len,
  bo2chs_out_if.source                               out_ch
);

  localparam int OB    = OFFSET_BITS;
  localparam int LW    = OB - bo2chs_pkg::BASE_SHIFT;
  localparam int RW    = bo2chs_pkg::SPT_W;
  localparam int LEN_W = bo2chs_pkg::LEN_W;
  localparam int CYL_W = bo2chs_pkg::CYL_W;
  localparam int CE_W  = LW + 1 + bo2chs_pkg::BASE_SHIFT + bo2chs_pkg::CODE_SHIFT_MAX;
  localparam int SUM_W = ((OB > LEN_W) ? OB : LEN_W) + 1;

  // stage a: cylinder, head, sector and end of cylinder in sectors
  logic              va_r;
  logic [LW-1:0]     cyl_a_r;
  logic              hd_a_r;
  logic [RW-1:0]     sec_a_r;
  logic [LW:0]       ce_sec_a_r;
  logic [OB-1:0]     off_a_r;
  logic [LEN_W-1:0]  len_a_r;

  // stage b: byte positions and saturated cylinder
  logic              vb_r;
  logic [CE_W-1:0]   ce_b_r;
  logic [SUM_W-1:0]  end_pos_b_r;
  logic [LEN_W-1:0]  diff_b_r;
  logic [LEN_W-1:0]  len_b_r;
  logic [CYL_W-1:0]  rcyl_b_r;
  logic              oor_b_r;
  logic [bo2chs_pkg::SEEK_W-1:0] seek_b_r;
  logic              hd_b_r;
  logic [RW-1:0]     sec_b_r;

  // stage c: output register
  logic              vc_r;
  logic [CYL_W-1:0]  cyl_c_r;
  logic              hd_c_r;
  logic [RW-1:0]     sec_c_r;
  logic [bo2chs_pkg::SEEK_W-1:0] seek_c_r;
  logic [LEN_W-1:0]  tlen_c_r;
  logic              trim_c_r;
  logic              oor_c_r;

  logic              en_a;
  logic              en_b;
  logic              en_c;

  logic              hd_nxt;
  logic [LW-1:0]     cyl_nxt;
  logic [RW:0]       per_cyl;
  logic [RW:0]       hd_spt;
  logic [RW:0]       tail;
  logic [LW:0]       ce_sec_nxt;
  logic [RW-1:0]     sec_nxt;

  logic [CE_W-1:0]   ce_nxt;
  logic [SUM_W-1:0]  end_pos_nxt;
  logic [LEN_W-1:0]  diff_nxt;
  logic              oor_nxt;
  logic [CYL_W-1:0]  rcyl_nxt;
  logic [bo2chs_pkg::SEEK_W-1:0] seek_nxt;

  logic              trim_nxt;
  logic [LEN_W-1:0]  tlen_nxt;

  assign en_c     = !vc_r || out_ch.ready;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  // start of this cylinder is lsec minus (hd * spt + rem); add one cylinder on top
  assign hd_nxt     = geom.heads2 & quo[0];
  assign cyl_nxt    = geom.heads2 ? (quo >> 1) : quo;
  assign per_cyl    = geom.heads2 ? {geom.spt, 1'b0} : {1'b0, geom.spt};
  assign hd_spt     = hd_nxt ? {1'b0, geom.spt} : '0;
  assign tail       = per_cyl - hd_spt - {1'b0, rem};
  assign ce_sec_nxt = (LW+1)'(lsec) + (LW+1)'(tail);
  assign sec_nxt    = rem + RW'(1);

  assign ce_nxt = CE_W'({ce_sec_a_r, {bo2chs_pkg::BASE_SHIFT{1'b0}}}) << geom.size_code;
  assign end_pos_nxt = SUM_W'(off_a_r) + SUM_W'(len_a_r);
  assign diff_nxt    = LEN_W'(ce_nxt - CE_W'(off_a_r));
  assign oor_nxt     = |cyl_a_r[LW-1:CYL_W];
  assign rcyl_nxt    = oor_nxt ? '1 : cyl_a_r[CYL_W-1:0];
  assign seek_nxt    = geom.steps2 ? {rcyl_nxt, 1'b0} : {1'b0, rcyl_nxt};

  // ending exactly on the boundary is no cut
  assign trim_nxt = CE_W'(end_pos_b_r) > ce_b_r;
  assign tlen_nxt = trim_nxt ? diff_b_r : len_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
      if (en_c) begin
        vc_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      cyl_a_r    <= cyl_nxt;
      hd_a_r     <= hd_nxt;
      sec_a_r    <= sec_nxt;
      ce_sec_a_r <= ce_sec_nxt;
      off_a_r    <= off;
      len_a_r    <= len;
    end
    if (en_b) begin
      ce_b_r      <= ce_nxt;
      end_pos_b_r <= end_pos_nxt;
      diff_b_r    <= diff_nxt;
      len_b_r     <= len_a_r;
      rcyl_b_r    <= rcyl_nxt;
      oor_b_r     <= oor_nxt;
      seek_b_r    <= seek_nxt;
      hd_b_r      <= hd_a_r;
      sec_b_r     <= sec_a_r;
    end
    if (en_c) begin
      cyl_c_r  <= rcyl_b_r;
      hd_c_r   <= hd_b_r;
      sec_c_r  <= sec_b_r;
      seek_c_r <= seek_b_r;
      tlen_c_r <= tlen_nxt;
      trim_c_r <= trim_nxt;
      oor_c_r  <= oor_b_r;
    end
  end

  assign out_ch.valid          = vc_r;
  assign out_ch.cylinder       = cyl_c_r;
  assign out_ch.head           = hd_c_r;
  assign out_ch.sector         = sec_c_r;
  assign out_ch.seek_track     = seek_c_r;
  assign out_ch.trimmed_length = tlen_c_r;
  assign out_ch.was_trimmed    = trim_c_r;
  assign out_ch.out_of_range   = oor_c_r;

endmodule

// ===== rtl/byte_offset_to_chs_with_trim.sv =====
// Byte offset to cylinder/head/sector translation with a trim at the cylinder end.
// in_ch takes a byte offset and a transfer length, out_ch gives cylinder (saturated
// at 255 with out_of_range), head, one-based sector, seek track and the length cut
// so the transfer stops at the end of the starting cylinder (was_trimmed).
// cfg_ch writes the geometry registers by index: sector size code, sectors per
// track, head count, steps per cylinder; cfg_ch.ready is always high. Write them
// only while no item is in flight.
// Items pass the input register, the divider stages and post stages a, b and c;
// the divider by sectors per track resolves four quotient bits per stage and sets
// the depth. One item is accepted per cycle unless a full pipeline stalls in_ch.
// Reset clears every valid bit and loads the default geometry: 512 byte sectors,
// 18 sectors per track, two heads, one step per cylinder.
// When out_ch stalls, items keep moving into empty stages behind the output
// register; in_ch.ready drops only once the whole pipeline is full.
module byte_offset_to_chs_with_trim #(
  parameter int OFFSET_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  bo2chs_in_if.sink     in_ch,
  bo2chs_out_if.source  out_ch,
  bo2chs_cfg_if.sink    cfg_ch
);

  `include "assert_macros.svh"

  localparam int OB     = OFFSET_BITS;
  localparam int LW     = OB - bo2chs_pkg::BASE_SHIFT;
  localparam int LEN_W  = bo2chs_pkg::LEN_W;
  localparam int SIDE_W = OB + LEN_W + LW;

  bo2chs_pkg::geom_t  geom;

  logic               v_f_r;
  logic [OB-1:0]      off_f_r;
  logic [LEN_W-1:0]   len_f_r;
  logic [LW-1:0]      lsec_f_r;
  logic               en_f;
  logic [3:0]         shamt;
  logic [LW-1:0]      lsec_nxt;

  logic               div_in_ready;
  logic               div_out_valid;
  logic [LW-1:0]      div_quo;
  logic [bo2chs_pkg::SPT_W-1:0] div_rem;
  logic [SIDE_W-1:0]  div_side;
  logic               post_ready;

  bo2chs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .geom   (geom)
  );

  // logical sector from the byte offset
  assign shamt    = 4'(bo2chs_pkg::BASE_SHIFT) + 4'(geom.size_code);
  assign lsec_nxt = LW'(in_ch.byte_offset >> shamt);

  assign en_f        = !v_f_r || div_in_ready;
  assign in_ch.ready = en_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en_f) begin
      v_f_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      off_f_r  <= in_ch.byte_offset;
      len_f_r  <= in_ch.transfer_length;
      lsec_f_r <= lsec_nxt;
    end
  end

  bo2chs_div_pipe #(
    .DW     (LW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .divisor   (geom.spt),
    .in_valid  (v_f_r),
    .in_ready  (div_in_ready),
    .in_num    (lsec_f_r),
    .in_side   ({off_f_r, len_f_r, lsec_f_r}),
    .out_valid (div_out_valid),
    .out_ready (post_ready),
    .out_quo   (div_quo),
    .out_rem   (div_rem),
    .out_side  (div_side)
  );

  bo2chs_post #(
    .OFFSET_BITS (OB)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (div_out_valid),
    .in_ready (post_ready),
    .quo      (div_quo),
    .rem      (div_rem),
    .lsec     (div_side[LW-1:0]),
    .off      (div_side[SIDE_W-1 -: OB]),
    .len      (div_side[LW +: LEN_W]),
    .out_ch   (out_ch)
  );

  `CHK_ALWAYS(a_rst_clears, !rst_n |=> (!out_ch.valid && !v_f_r), "valid left set by reset")
  `CHK_RST(a_accept_lands, (in_ch.valid && in_ch.ready) |=> v_f_r, "accepted item dropped")
  `CHK_RST(a_sat_cyl, (out_ch.valid && out_ch.out_of_range) |-> (out_ch.cylinder == 8'hFF), "cylinder not saturated")
  `CHK_RST(a_trim_len, (out_ch.valid && out_ch.was_trimmed) |-> (out_ch.trimmed_length != '0), "cut length is zero")
  `CHK_RST(a_seek, out_ch.valid |-> ((out_ch.seek_track == 9'(out_ch.cylinder)) || (out_ch.seek_track == (9'(out_ch.cylinder) << 1))), "seek track mismatch")
  `CHK_RST(a_sector, out_ch.valid |-> (out_ch.sector != '0), "sector number zero")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BASE_SHIFT  = bo2chs_pkg::BASE_SHIFT;
  localparam int DIV_STEP    = bo2chs_pkg::DIV_STEP;
  localparam int CYL_W       = bo2chs_pkg::CYL_W;
  localparam int SPT_W       = bo2chs_pkg::SPT_W;
  localparam int SEEK_W      = bo2chs_pkg::SEEK_W;
  localparam int LEN_W       = bo2chs_pkg::LEN_W;
  localparam int CODE_W      = bo2chs_pkg::CODE_W;
  localparam int CFG_ADDR_W  = bo2chs_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = bo2chs_pkg::CFG_DATA_W;

  localparam int OFFSET_W    = 24;
  localparam int LATENCY     = (OFFSET_W - BASE_SHIFT + DIV_STEP - 1) / DIV_STEP + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int CYL_MAX     = (1 << CYL_W) - 1;
  localparam int RST_CYL_B   = 18432;   // 36 sectors of 512 bytes
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 4'd12;

  typedef struct packed {
    logic [CYL_W-1:0]  cylinder;
    logic              head;
    logic [SPT_W-1:0]  sector;
    logic [SEEK_W-1:0] seek_track;
    logic [LEN_W-1:0]  trimmed_length;
    logic              was_trimmed;
    logic              out_of_range;
  } chs_result_t;

  logic clk;
  logic rst_n;

  bo2chs_in_if #(.OFFSET_BITS(OFFSET_W)) in_ch ();
  bo2chs_out_if out_ch ();
  bo2chs_cfg_if cfg_ch ();

  byte_offset_to_chs_with_trim #(.OFFSET_BITS(OFFSET_W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // geometry as last written
  logic [CODE_W-1:0] geo_code;
  logic [SPT_W-1:0]  geo_spt;
  logic [1:0]        geo_heads;
  logic [1:0]        geo_steps;

  chs_result_t chs_expected_q[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          hold_cycles = 0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned one_or_two(logic [1:0] v);
    if (v == 2'd0) return 1;
    if (v > 2'd2) return 2;
    return v;
  endfunction

  function automatic longint unsigned eff_spt();
    return (geo_spt == '0) ? 1 : geo_spt;
  endfunction

  function automatic longint unsigned cyl_bytes();
    return (eff_spt() * one_or_two(geo_heads)) << (BASE_SHIFT + geo_code);
  endfunction

  function automatic chs_result_t translate(logic [OFFSET_W-1:0] off_in,
                                            logic [LEN_W-1:0] len_in);
    longint unsigned off, len, spt, heads, shift, per_cyl, lsec, cyl, cyl_end, rcyl;
    chs_result_t r;
    off     = off_in;
    len     = len_in;
    spt     = eff_spt();
    heads   = one_or_two(geo_heads);
    shift   = BASE_SHIFT + geo_code;
    per_cyl = spt * heads;
    lsec    = off >> shift;
    cyl     = lsec / per_cyl;
    cyl_end = ((cyl + 1) * per_cyl) << shift;
    rcyl    = (cyl > CYL_MAX) ? CYL_MAX : cyl;
    r.cylinder       = CYL_W'(rcyl);
    r.head           = 1'((lsec / spt) % heads);
    r.sector         = SPT_W'((lsec % spt) + 1);
    r.seek_track     = SEEK_W'(rcyl * one_or_two(geo_steps));
    r.was_trimmed    = (off + len > cyl_end);
    r.trimmed_length = r.was_trimmed ? LEN_W'(cyl_end - off) : LEN_W'(len);
    r.out_of_range   = (cyl > CYL_MAX);
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      bo2chs_pkg::REG_SECTOR_SIZE_CODE:   geo_code  = val[CODE_W-1:0];
      bo2chs_pkg::REG_SECTORS_PER_TRACK:  geo_spt   = val[SPT_W-1:0];
      bo2chs_pkg::REG_HEAD_COUNT:         geo_heads = val[1:0];
      bo2chs_pkg::REG_STEPS_PER_CYLINDER: geo_steps = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] code, input logic [CFG_DATA_W-1:0] spt,
                              input logic [CFG_DATA_W-1:0] heads,
                              input logic [CFG_DATA_W-1:0] steps);
    write_reg(bo2chs_pkg::REG_SECTOR_SIZE_CODE, code);
    write_reg(bo2chs_pkg::REG_SECTORS_PER_TRACK, spt);
    write_reg(bo2chs_pkg::REG_HEAD_COUNT, heads);
    write_reg(bo2chs_pkg::REG_STEPS_PER_CYLINDER, steps);
  endtask

  // valid stays high between back to back items
  task automatic send_request(input logic [OFFSET_W-1:0] off, input logic [LEN_W-1:0] len);
    int gap;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.byte_offset     <= off;
    in_ch.transfer_length <= len;
    do @(posedge clk); while (!in_ch.ready);
    chs_expected_q.push_back(translate(off, len));
  endtask

  task automatic send_random_request();
    longint unsigned ss, cb, max_cyl, cyl, off, len, span;
    ss = 64'd128 << geo_code;
    cb = cyl_bytes();
    if ($urandom_range(0, 9) < 2) begin
      off = $urandom;
      len = $urandom;
    end else begin
      // aim near cylinder ends and around the saturation point
      max_cyl = ((1 << OFFSET_W) - 1) / cb;
      if (max_cyl > 300) max_cyl = 300;
      cyl = $urandom_range(0, max_cyl);
      off = cyl * cb + $urandom_range(0, cb / ss - 1) * ss;
      if ($urandom_range(0, 7) == 0) off = off + $urandom_range(1, ss - 1);
      span = (cyl + 1) * cb - off;
      case ($urandom_range(0, 4))
        0: len = span;
        1: len = span + ss;
        2: len = (span > ss) ? span - ss : 0;
        3: len = $urandom_range(0, 8) * ss;
        default: len = span + $urandom_range(0, 3) * cb + $urandom_range(0, 1) * ss;
      endcase
    end
    send_request(off[OFFSET_W-1:0], len[LEN_W-1:0]);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (chs_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_reset_geometry();
    send_request('0, '0);
    send_request('0, '1);
    send_request('1, '0);
    send_request('1, '1);
    send_request(24'd9216, 24'd512);              // head one, sector one
    send_request(24'd8704, 24'd512);              // last sector of head zero
    send_request('0, LEN_W'(RST_CYL_B));          // ends on the boundary
    send_request(24'd512, LEN_W'(RST_CYL_B));
    send_request(24'd700, 24'd20000);             // unaligned offset
    send_request('0, 24'd100000);                 // several boundaries
    send_request(OFFSET_W'(RST_CYL_B * 255), 24'd512);
    send_request(OFFSET_W'(RST_CYL_B * 256), 24'd40000);   // first saturated cylinder
    drain_and_settle();
  endtask

  task automatic test_clamped_geometry();
    // zero track size and head count, three steps, spare bits set
    set_geometry(8'hFC, 8'hC0, 8'h00, 8'h03);
    write_reg(REG_SPARE, 8'hFF);
    send_request('0, 24'd128);
    send_request(24'd127, 24'd256);
    send_request(24'd100, '0);
    send_request(24'd32640, 24'd128);
    send_request(24'd32768, 24'd300);
    send_request('1, '1);
    drain_and_settle();
  endtask

  task automatic test_largest_geometry();
    set_geometry(8'h03, 8'h3F, 8'hFF, 8'h02);
    send_request('0, '1);
    send_request(24'd64512, 24'd1024);            // head one, sector one
    send_request(24'd63488, 24'd2048);            // sector 63
    send_request(24'd16773120, '1);
    send_request('1, 24'd1024);
    drain_and_settle();
  endtask

  task automatic test_random_geometry();
    for (int phase = 0; phase < 8; phase++) begin
      set_geometry(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)),
                   CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)));
      src_idle_en = (phase != 3);
      snk_idle_en = (phase != 5);
      for (int n = 0; n < 80; n++) send_random_request();
      drain_and_settle();
    end
  endtask

  task automatic test_output_hold();
    set_geometry(8'h02, 8'h12, 8'h02, 8'h01);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_cycles = LONG_HOLD;
    for (int n = 0; n < 60; n++) send_random_request();
    drain_and_settle();
  endtask

  task automatic test_full_rate();
    set_geometry(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(1, 63)),
                 CFG_DATA_W'($urandom_range(1, 2)), CFG_DATA_W'($urandom_range(1, 2)));
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int n = 0; n < 100; n++) send_random_request();
    drain_and_settle();
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.byte_offset     = '0;
    in_ch.transfer_length = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.addr           = '0;
    cfg_ch.data           = '0;
    geo_code              = bo2chs_pkg::RST_SIZE_CODE;
    geo_spt               = bo2chs_pkg::RST_SPT;
    geo_heads             = bo2chs_pkg::RST_HEADS2 ? 2'd2 : 2'd1;
    geo_steps             = bo2chs_pkg::RST_STEPS2 ? 2'd2 : 2'd1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_clamped_geometry();
    test_largest_geometry();
    test_random_geometry();
    test_output_hold();
    test_full_rate();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    chs_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cylinder       = out_ch.cylinder;
      got.head           = out_ch.head;
      got.sector         = out_ch.sector;
      got.seek_track     = out_ch.seek_track;
      got.trimmed_length = out_ch.trimmed_length;
      got.was_trimmed    = out_ch.was_trimmed;
      got.out_of_range   = out_ch.out_of_range;
      if (chs_expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none got %p", $time, got);
      end else begin
        want = chs_expected_q.pop_front();
        compare_field("cylinder", want.cylinder, got.cylinder);
        compare_field("head", want.head, got.head);
        compare_field("sector", want.sector, got.sector);
        compare_field("seek_track", want.seek_track, got.seek_track);
        compare_field("trimmed_length", want.trimmed_length, got.trimmed_length);
        compare_field("was_trimmed", want.was_trimmed, got.was_trimmed);
        compare_field("out_of_range", want.out_of_range, got.out_of_range);
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bo2chs_pkg.sv
rtl/bo2chs_in_if.sv
rtl/bo2chs_out_if.sv
rtl/bo2chs_cfg_if.sv
rtl/bo2chs_cfg_regs.sv
rtl/bo2chs_div_pipe.sv
rtl/bo2chs_post.sv
rtl/byte_offset_to_chs_with_trim.sv
dv/tb_top.sv
